### rtl/core/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants for the terminal line editor: request and result codes,
// line status codes, register indexes and the special characters.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int TLE_LINE_DEPTH = 256;

  // request types on the input channel
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_EOF  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // result kinds
  localparam logic [1:0] RES_ECHO = 2'd0;
  localparam logic [1:0] RES_LINE = 2'd1;
  localparam logic [1:0] RES_READ = 2'd2;

  // line status on a finished line
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_EOF      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_ECHO_ENABLE   = 2'd1;

  localparam logic [8:0] CFG_CAPACITY_RST = 9'd256;

  // characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

### rtl/core/tle_ram.sv
// ----------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical-mode line editor: edits received bytes into a line store, echoes,
// reports finished lines and serves reads of the store.
// ----------------------------------------------------------------------------
// Input beats carry a request: a received byte, end of input, or a read of
// line store entry in_read_index. Each request gives zero to three result
// beats (echo bytes, a line-finished report, or read data); out_last marks
// the final result beat of a request.
// The first result passes through the decode register, loaded at the accepting
// edge, and then through the output register.
// Throughput: one request per cycle while each gives at most one result and
// out_ready is high; extra results of a request hold the input back.
// A stalled receiver holds the output and decode registers; one further
// request is absorbed, then in_ready drops. in_ready follows out_ready
// combinationally while one result is left in the decode register.
// Reset clears the count and flags, sets capacity 256 and echo on; the line
// store is not cleared. The configuration port is always ready.
// ----------------------------------------------------------------------------
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_DEPTH = TLE_LINE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  // requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_res_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_line_status,
  output logic [7:0] out_line_chars,
  output logic       out_last
);

  localparam int         AW      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [8:0] CAP_MAX = (LINE_DEPTH < 256) ? 9'(LINE_DEPTH) : 9'd256;

  // configuration and line state
  logic [8:0] line_capacity_r;
  logic       echo_enable_r;
  logic [7:0] char_count_r, char_count_nxt;
  logic       overflow_r, overflow_nxt;
  logic       swallow_lf_r, swallow_lf_nxt;

  // decoded results of the last request, slot 0 goes out next
  logic [1:0] gen_cnt_r;
  logic [1:0] gen_kind_r [3];
  logic [7:0] gen_byte_r [3];
  logic [1:0] gen_status_r;
  logic [7:0] gen_len_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_res_kind_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_line_status_r;
  logic [7:0] out_line_chars_r;
  logic       out_last_r;

  // decode
  logic [1:0] seq_cnt;
  logic [1:0] seq_kind [3];
  logic [7:0] seq_byte [3];
  logic [1:0] seq_status;
  logic [1:0] finish_status;
  logic [8:0] eff_cap;
  logic       line_full;
  logic       store_ok;
  logic       ram_we, ram_re;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  logic       in_fire;
  logic       gen_move;

  // read index modulo the store depth
  logic [AW-1:0] idx_mod [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign idx_mod[g] = AW'(g % LINE_DEPTH);
  end

  assign cfg_ready = 1'b1;
  assign gen_move  = (gen_cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign in_ready  = (gen_cnt_r == 2'd0) || ((gen_cnt_r == 2'd1) && gen_move);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    eff_cap = line_capacity_r;
    if (eff_cap == 9'd0) begin
      eff_cap = 9'd1;
    end
    if (eff_cap > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end
  end

  assign line_full     = ({1'b0, char_count_r} + 9'd1) >= eff_cap;
  assign store_ok      = 32'(char_count_r) < LINE_DEPTH;
  assign finish_status = overflow_r ? STAT_OVERFLOW : STAT_OK;

  always_comb begin
    seq_cnt        = 2'd0;
    for (int i = 0; i < 3; i++) begin
      seq_kind[i] = RES_ECHO;
      seq_byte[i] = 8'h00;
    end
    seq_status     = STAT_OK;
    char_count_nxt = char_count_r;
    overflow_nxt   = overflow_r;
    swallow_lf_nxt = swallow_lf_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_wdata      = 8'h00;
    case (in_req_type)
      REQ_BYTE: begin
        swallow_lf_nxt = (in_rx_byte == CH_CR);
        if (swallow_lf_r && (in_rx_byte == CH_LF)) begin
          swallow_lf_nxt = 1'b0;
        end else if (in_rx_byte inside {CH_CR, CH_LF}) begin
          // line end: zero terminator into the store, count and flag cleared
          seq_status     = finish_status;
          char_count_nxt = 8'd0;
          overflow_nxt   = 1'b0;
          ram_we         = store_ok;
          if (echo_enable_r) begin
            seq_cnt     = 2'd3;
            seq_byte[0] = CH_CR;
            seq_byte[1] = CH_LF;
            seq_kind[2] = RES_LINE;
          end else begin
            seq_cnt     = 2'd1;
            seq_kind[0] = RES_LINE;
          end
        end else if (in_rx_byte inside {CH_BS, CH_DEL}) begin
          if (!overflow_r && (char_count_r != 8'd0)) begin
            char_count_nxt = char_count_r - 8'd1;
            if (echo_enable_r) begin
              seq_cnt     = 2'd3;
              seq_byte[0] = CH_BS;
              seq_byte[1] = CH_SPACE;
              seq_byte[2] = CH_BS;
            end
          end
        end else if (!((in_rx_byte < CH_SPACE) && (in_rx_byte != CH_TAB)) && !overflow_r) begin
          if (line_full) begin
            overflow_nxt = 1'b1;
            if (echo_enable_r) begin
              seq_cnt     = 2'd1;
              seq_byte[0] = CH_BELL;
            end
          end else begin
            ram_we         = store_ok;
            ram_wdata      = in_rx_byte;
            char_count_nxt = char_count_r + 8'd1;
            if (echo_enable_r) begin
              seq_cnt     = 2'd1;
              seq_byte[0] = in_rx_byte;
            end
          end
        end
      end
      REQ_EOF: begin
        seq_status     = (char_count_r == 8'd0) ? STAT_EOF : finish_status;
        seq_cnt        = 2'd1;
        seq_kind[0]    = RES_LINE;
        char_count_nxt = 8'd0;
        overflow_nxt   = 1'b0;
        ram_we         = store_ok;
      end
      REQ_READ: begin
        seq_cnt     = 2'd1;
        seq_kind[0] = RES_READ;
        ram_re      = 1'b1;
      end
      default: begin
        seq_cnt = 2'd0;
      end
    endcase
  end

  tle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_fire && ram_we),
    .waddr (AW'(char_count_r)),
    .wdata (ram_wdata),
    .re    (in_fire && ram_re),
    .raddr (idx_mod[in_read_index]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_capacity_r <= CFG_CAPACITY_RST;
      echo_enable_r   <= 1'b1;
      char_count_r    <= 8'd0;
      overflow_r      <= 1'b0;
      swallow_lf_r    <= 1'b0;
      gen_cnt_r       <= 2'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_CAPACITY: line_capacity_r <= cfg_wdata;
          CFG_ECHO_ENABLE:   echo_enable_r   <= cfg_wdata[0];
          default:           ;
        endcase
      end
      if (in_fire) begin
        char_count_r <= char_count_nxt;
        overflow_r   <= overflow_nxt;
        swallow_lf_r <= swallow_lf_nxt;
        gen_cnt_r    <= seq_cnt;
      end else if (gen_move) begin
        gen_cnt_r <= gen_cnt_r - 2'd1;
      end
      if (gen_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      gen_kind_r   <= seq_kind;
      gen_byte_r   <= seq_byte;
      gen_status_r <= seq_status;
      gen_len_r    <= char_count_r;
    end else if (gen_move) begin
      gen_kind_r[0] <= gen_kind_r[1];
      gen_kind_r[1] <= gen_kind_r[2];
      gen_byte_r[0] <= gen_byte_r[1];
      gen_byte_r[1] <= gen_byte_r[2];
    end
    if (gen_move) begin
      out_res_kind_r    <= gen_kind_r[0];
      out_byte_r        <= (gen_kind_r[0] == RES_READ) ? ram_rdata : gen_byte_r[0];
      out_line_status_r <= (gen_kind_r[0] == RES_LINE) ? gen_status_r : STAT_OK;
      out_line_chars_r  <= (gen_kind_r[0] == RES_LINE) ? gen_len_r : 8'd0;
      out_last_r        <= (gen_cnt_r == 2'd1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_kind    = out_res_kind_r;
  assign out_byte        = out_byte_r;
  assign out_line_status = out_line_status_r;
  assign out_line_chars  = out_line_chars_r;
  assign out_last        = out_last_r;

  // a beat that is not the last of its request must have the rest queued
  a_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> gen_cnt_r != 2'd0)
    else $error("non-last result beat with nothing queued");

  a_read_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == REQ_READ) |=>
      (gen_cnt_r == 2'd1) && (gen_kind_r[0] == RES_READ))
    else $error("read request not queued as a single read result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, char_count_r} < CAP_MAX)
    else $error("character count beyond store capacity");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == REQ_EOF) |=> (char_count_r == 8'd0) && !overflow_r)
    else $error("end of input did not clear the line state");

endmodule
